// File: rtl/pjd_pkg.sv
// Shared types and codes of the priority job dispatcher.
`default_nettype none
package pjd_pkg;

  localparam logic [2:0] ACT_ENQ_PRIO = 3'd0;
  localparam logic [2:0] ACT_ENQ_HEAD = 3'd1;
  localparam logic [2:0] ACT_PURGE    = 3'd2;
  localparam logic [2:0] ACT_FINISH   = 3'd3;
  localparam logic [2:0] ACT_PASS     = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic KIND_LAUNCH = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] REG_PROC_MIN   = 3'd0;
  localparam logic [2:0] REG_PROC_MAX   = 3'd1;
  localparam logic [2:0] REG_LOAD_LIMIT = 3'd2;
  localparam logic [2:0] REG_RES_LIM_0  = 3'd3;
  localparam logic [2:0] REG_RES_LIM_1  = 3'd4;
  localparam logic [2:0] REG_RES_LIM_2  = 3'd5;
  localparam logic [2:0] REG_RES_LIM_3  = 3'd6;
  localparam logic [2:0] REG_PAUSED     = 3'd7;

  localparam logic [4:0] MAX_LAUNCH = 5'd16;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] job_id;
    logic [7:0] priority_req;
    logic [3:0] resource_mask;
    logic       load_valid;
    logic [7:0] load_sample;
  } pjd_req_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] launched_id;
    logic [1:0] status;
    logic       last;
  } pjd_res_t;

  typedef struct packed {
    logic [7:0]      proc_min;
    logic [7:0]      proc_max;
    logic [7:0]      load_limit;
    logic [3:0][7:0] res_limit;
    logic [3:0]      paused_mask;
  } pjd_cfg_t;

  typedef struct packed {
    logic [7:0] job;
    logic [7:0] prio;
    logic [3:0] res;
  } pjd_qent_t;

  typedef struct packed {
    logic [7:0] job;
    logic [3:0] res;
  } pjd_rent_t;

endpackage
`default_nettype wire

// File: rtl/pjd_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none
module pjd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/pjd_admit.sv
// Admission check unit shared by every step of a dispatch pass.
`default_nettype none
module pjd_admit import pjd_pkg::*; #(
  parameter int RUN_DEPTH     = 16,
  parameter int NUM_RESOURCES = 4,
  parameter int RCW           = 5
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pjd_cfg_t                           cfg_i,
  input  wire logic [RCW-1:0]                     running_i,
  input  wire logic [NUM_RESOURCES-1:0][RCW-1:0]  res_running_i,
  input  wire logic [RCW-1:0]                     at_sample_i,
  input  wire logic [7:0]                         base_load_i,
  input  wire logic [3:0]                         mask_i,
  output logic                                    admit_o
);

  logic [9:0]         run_ext;
  logic signed [10:0] est;
  logic               count_ok;
  logic               res_ok;

  always_comb begin
    run_ext  = 10'(running_i);
    est      = $signed({3'b000, base_load_i}) + $signed(11'(running_i))
             - $signed(11'(at_sample_i));
    count_ok = (run_ext < 10'(RUN_DEPTH)) && (run_ext < {2'b00, cfg_i.proc_max});
    if (run_ext >= {2'b00, cfg_i.proc_min}) begin
      if (est >= $signed({3'b000, cfg_i.load_limit})) begin
        count_ok = 1'b0;
      end
    end
    res_ok = 1'b1;
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      if (mask_i[r] && (cfg_i.paused_mask[r] ||
          (10'(res_running_i[r]) >= {2'b00, cfg_i.res_limit[r]}))) begin
        res_ok = 1'b0;
      end
    end
    admit_o = count_ok && res_ok;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    admit_o |-> (run_ext < 10'(RUN_DEPTH)))
    else $error("admission granted with a full run table");

endmodule
`default_nettype wire

// File: rtl/priority_job_dispatcher_unit.sv
// Top level of the priority job dispatcher: sequencer, counters and tables.
// Usage:
//   A request is taken at a clock edge where start is high and busy is low.
//   busy stays high until the request is finished. Each result appears on
//   res_o for one cycle with res_valid_o high; the receiver cannot stall.
//   A request gives zero or more launch results in queue order, then one
//   status result with last set.
//   An enqueue walks the queue to insert the new entry unless it is full, then
//   runs the pass; a pass and a purge walk the queue, a finish the run table.
//   Results appear in the cycle after they are formed. Every element takes a
//   read state and an evaluation state because the queue and run tables sit in
//   RAMs with a registered read port and the single admission unit judges one
//   entry at a time. The configuration channel is always ready; the user must
//   see that registers are written only while the block is idle, which the block
//   itself does not enforce. Reset empties the queue and the run table at once
//   and loads the register reset values; no clearing pass is needed.
`default_nettype none
module priority_job_dispatcher_unit import pjd_pkg::*; #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int RUN_DEPTH     = 16,
  parameter int NUM_RESOURCES = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire pjd_req_t req_i,
  output logic          res_valid_o,
  output pjd_res_t      res_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RAW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int RCW = $clog2(RUN_DEPTH + 1);
  localparam int IW  = (QCW > RCW) ? QCW : RCW;
  localparam logic [3:0] RES_KEEP = 4'((1 << NUM_RESOURCES) - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_STAT = 2'd3;

  localparam logic [1:0] OP_INS   = 2'd0;
  localparam logic [1:0] OP_PASS  = 2'd1;
  localparam logic [1:0] OP_PURGE = 2'd2;
  localparam logic [1:0] OP_FIN   = 2'd3;

  pjd_cfg_t cfg_q;

  logic [1:0]      state_q, state_d;
  logic [1:0]      op_q, op_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [QCW-1:0]  wk_q, wk_d;
  logic [QCW-1:0]  qc_q, qc_d;
  logic [RCW-1:0]  rc_q, rc_d;
  logic [RCW-1:0]  ras_q, ras_d;
  logic [7:0]      base_q, base_d;
  logic [NUM_RESOURCES-1:0][RCW-1:0] rr_q, rr_d;
  logic [4:0]      n_q, n_d;
  logic [1:0]      st_q, st_d;
  logic            head_q, head_d;
  logic            ins_done_q, ins_done_d;
  logic            found_q, found_d;
  pjd_qent_t       new_q, new_d;
  pjd_qent_t       carry_q, carry_d;
  logic            res_valid_q, res_valid_d;
  pjd_res_t        res_q, res_d;

  logic            q_we, r_we;
  logic [QAW-1:0]  q_waddr;
  logic [RAW-1:0]  r_waddr;
  pjd_qent_t       q_wdata, q_rdata;
  pjd_rent_t       r_wdata, r_rdata;
  logic            admit;
  logic [IW-1:0]   lim;
  logic [IW-1:0]   idx_m1;

  pjd_ram #(.WIDTH($bits(pjd_qent_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (idx_q[QAW-1:0]),
    .rdata_o (q_rdata)
  );

  pjd_ram #(.WIDTH($bits(pjd_rent_t)), .DEPTH(RUN_DEPTH)) u_run (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (idx_q[RAW-1:0]),
    .rdata_o (r_rdata)
  );

  pjd_admit #(.RUN_DEPTH(RUN_DEPTH), .NUM_RESOURCES(NUM_RESOURCES), .RCW(RCW)) u_admit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .running_i     (rc_q),
    .res_running_i (rr_q),
    .at_sample_i   (ras_q),
    .base_load_i   (base_q),
    .mask_i        (q_rdata.res),
    .admit_o       (admit)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    wk_d        = wk_q;
    qc_d        = qc_q;
    rc_d        = rc_q;
    ras_d       = ras_q;
    base_d      = base_q;
    rr_d        = rr_q;
    n_d         = n_q;
    st_d        = st_q;
    head_d      = head_q;
    ins_done_d  = ins_done_q;
    found_d     = found_q;
    new_d       = new_q;
    carry_d     = carry_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    q_we        = 1'b0;
    q_waddr     = wk_q[QAW-1:0];
    q_wdata     = q_rdata;
    r_we        = 1'b0;
    r_waddr     = rc_q[RAW-1:0];
    r_wdata     = '{job: q_rdata.job, res: q_rdata.res};
    lim         = (op_q == OP_FIN) ? IW'(rc_q) : IW'(qc_q);
    idx_m1      = idx_q - IW'(1);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.load_valid) begin
            base_d = req_i.load_sample;
            ras_d  = rc_q;
          end
          new_d      = '{job: req_i.job_id, prio: req_i.priority_req,
                         res: req_i.resource_mask & RES_KEEP};
          head_d     = (req_i.action == ACT_ENQ_HEAD);
          idx_d      = '0;
          wk_d       = '0;
          n_d        = '0;
          st_d       = ST_OK;
          ins_done_d = 1'b0;
          found_d    = 1'b0;
          state_d    = S_READ;
          case (req_i.action)
            ACT_ENQ_PRIO, ACT_ENQ_HEAD: begin
              if (qc_q == QCW'(QUEUE_DEPTH)) begin
                st_d = ST_FULL;
                op_d = OP_PASS;
              end else begin
                op_d = OP_INS;
              end
            end
            ACT_PURGE:  op_d = OP_PURGE;
            ACT_FINISH: op_d = OP_FIN;
            ACT_PASS:   op_d = OP_PASS;
            default:    state_d = S_STAT;
          endcase
        end
      end
      S_READ: begin
        if (idx_q < lim) begin
          state_d = S_EVAL;
        end else begin
          case (op_q)
            OP_INS: begin
              q_we    = 1'b1;
              q_waddr = idx_q[QAW-1:0];
              q_wdata = ins_done_q ? carry_q : new_q;
              qc_d    = qc_q + QCW'(1);
              op_d    = OP_PASS;
              idx_d   = '0;
              wk_d    = '0;
            end
            OP_PASS: begin
              qc_d    = wk_q;
              state_d = S_STAT;
            end
            OP_PURGE: begin
              if (wk_q == qc_q) begin
                st_d = ST_NOT_FOUND;
              end
              qc_d    = wk_q;
              state_d = S_STAT;
            end
            default: begin
              if (found_q) begin
                rc_d = rc_q - RCW'(1);
              end else begin
                st_d = ST_NOT_FOUND;
              end
              state_d = S_STAT;
            end
          endcase
        end
      end
      S_EVAL: begin
        idx_d   = idx_q + IW'(1);
        state_d = S_READ;
        case (op_q)
          OP_INS: begin
            if (!ins_done_q && (head_q || (new_q.prio > q_rdata.prio))) begin
              q_we       = 1'b1;
              q_waddr    = idx_q[QAW-1:0];
              q_wdata    = new_q;
              carry_d    = q_rdata;
              ins_done_d = 1'b1;
            end else if (ins_done_q) begin
              q_we    = 1'b1;
              q_waddr = idx_q[QAW-1:0];
              q_wdata = carry_q;
              carry_d = q_rdata;
            end
          end
          OP_PASS: begin
            if ((n_q < MAX_LAUNCH) && admit) begin
              r_we = 1'b1;
              rc_d = rc_q + RCW'(1);
              for (int r = 0; r < NUM_RESOURCES; r++) begin
                if (q_rdata.res[r]) begin
                  rr_d[r] = rr_q[r] + RCW'(1);
                end
              end
              n_d         = n_q + 5'd1;
              res_valid_d = 1'b1;
              res_d       = '{result_kind: KIND_LAUNCH, launched_id: q_rdata.job,
                              status: ST_OK, last: 1'b0};
            end else begin
              q_we = 1'b1;
              wk_d = wk_q + QCW'(1);
            end
          end
          OP_PURGE: begin
            if (q_rdata.job != new_q.job) begin
              q_we = 1'b1;
              wk_d = wk_q + QCW'(1);
            end
          end
          default: begin
            if (found_q) begin
              r_we    = 1'b1;
              r_waddr = idx_m1[RAW-1:0];
              r_wdata = r_rdata;
            end else if (r_rdata.job == new_q.job) begin
              found_d = 1'b1;
              for (int r = 0; r < NUM_RESOURCES; r++) begin
                if (r_rdata.res[r] && (rr_q[r] != '0)) begin
                  rr_d[r] = rr_q[r] - RCW'(1);
                end
              end
            end
          end
        endcase
      end
      default: begin
        res_valid_d = 1'b1;
        res_d       = '{result_kind: KIND_STATUS, launched_id: 8'd0,
                        status: st_q, last: 1'b1};
        state_d     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_PASS;
      qc_q        <= '0;
      rc_q        <= '0;
      ras_q       <= '0;
      base_q      <= '0;
      rr_q        <= '0;
      res_valid_q <= 1'b0;
      cfg_q       <= '{proc_min: 8'd0, proc_max: 8'd255, load_limit: 8'd255,
                       res_limit: {4{8'd255}}, paused_mask: 4'd0};
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      qc_q        <= qc_d;
      rc_q        <= rc_d;
      ras_q       <= ras_d;
      base_q      <= base_d;
      rr_q        <= rr_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PROC_MIN:   cfg_q.proc_min     <= cfg_data_i;
          REG_PROC_MAX:   cfg_q.proc_max     <= cfg_data_i;
          REG_LOAD_LIMIT: cfg_q.load_limit   <= cfg_data_i;
          REG_RES_LIM_0:  cfg_q.res_limit[0] <= cfg_data_i;
          REG_RES_LIM_1:  cfg_q.res_limit[1] <= cfg_data_i;
          REG_RES_LIM_2:  cfg_q.res_limit[2] <= cfg_data_i;
          REG_RES_LIM_3:  cfg_q.res_limit[3] <= cfg_data_i;
          REG_PAUSED:     cfg_q.paused_mask  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    wk_q       <= wk_d;
    n_q        <= n_d;
    st_q       <= st_d;
    head_q     <= head_d;
    ins_done_q <= ins_done_d;
    found_q    <= found_d;
    new_q      <= new_d;
    carry_q    <= carry_d;
    res_q      <= res_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken without the block becoming busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rc_q <= RCW'(RUN_DEPTH)) && (qc_q <= QCW'(QUEUE_DEPTH)))
    else $error("queue or run count beyond its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> !busy)
    else $error("status result delivered while the request is still running");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && op_q == OP_PASS) |-> (n_q <= MAX_LAUNCH))
    else $error("launch counter overran its cap");

endmodule
`default_nettype wire

// File: tb/tb_priority_job_dispatcher_unit.sv
// Self-checking testbench of the priority job dispatcher: directed and random requests.
`timescale 1ns / 100ps
module tb_priority_job_dispatcher_unit import pjd_pkg::*; ();

  localparam int QDEPTH = 16;
  localparam int RDEPTH = 16;
  localparam int NRES = 4;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE = 8;

  typedef struct {
    bit         is_cfg;
    logic [2:0] idx;
    logic [7:0] data;
    pjd_req_t   req;
  } stim_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start;
  logic       busy;
  pjd_req_t   req_d;
  logic       res_valid_o;
  pjd_res_t   res_o;
  logic       cfg_valid;
  logic       cfg_ready_o;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  stim_t    stim_q[$];
  pjd_res_t awaited_results[$];
  int       errors = 0;
  int       sent = 0;
  int       total_reqs = 0;
  int       calm = 0;
  int       quiet = 0;

  // Shadow configuration and dispatcher state.
  int         proc_min, proc_max, load_limit;
  int         res_limit[NRES];
  logic [3:0] paused;
  logic [7:0] q_job[QDEPTH];
  logic [7:0] q_prio[QDEPTH];
  logic [3:0] q_res[QDEPTH];
  int         q_cnt;
  logic [7:0] r_job[RDEPTH];
  logic [3:0] r_res[RDEPTH];
  int         run_cnt;
  int         res_run[NRES];
  int         base_load, run_at_sample;

  priority_job_dispatcher_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_d),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void write_reg(logic [2:0] idx, logic [7:0] v);
    case (idx)
      REG_PROC_MIN:   proc_min = int'(v);
      REG_PROC_MAX:   proc_max = int'(v);
      REG_LOAD_LIMIT: load_limit = int'(v);
      REG_RES_LIM_0:  res_limit[0] = int'(v);
      REG_RES_LIM_1:  res_limit[1] = int'(v);
      REG_RES_LIM_2:  res_limit[2] = int'(v);
      REG_RES_LIM_3:  res_limit[3] = int'(v);
      REG_PAUSED:     paused = v[3:0];
      default: ;
    endcase
  endfunction

  function automatic void push_result(logic kind, logic [7:0] id, logic [1:0] st, logic lst);
    pjd_res_t r;
    r.result_kind = kind;
    r.launched_id = id;
    r.status = st;
    r.last = lst;
    awaited_results.push_back(r);
  endfunction

  function automatic bit admissible(logic [3:0] m);
    int est;
    if (run_cnt >= RDEPTH || run_cnt >= proc_max) return 1'b0;
    if (run_cnt >= proc_min) begin
      est = base_load + run_cnt - run_at_sample;
      if (est >= load_limit) return 1'b0;
    end
    for (int r = 0; r < NRES; r++)
      if (m[r] && (paused[r] || res_run[r] >= res_limit[r])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void dispatch_pass();
    int keep;
    int n;
    keep = 0;
    n = 0;
    for (int i = 0; i < q_cnt; i++) begin
      if (n < MAX_LAUNCH && admissible(q_res[i])) begin
        r_job[run_cnt] = q_job[i];
        r_res[run_cnt] = q_res[i];
        run_cnt++;
        for (int r = 0; r < NRES; r++)
          if (q_res[i][r]) res_run[r]++;
        push_result(KIND_LAUNCH, q_job[i], ST_OK, 1'b0);
        n++;
      end else begin
        q_job[keep] = q_job[i];
        q_prio[keep] = q_prio[i];
        q_res[keep] = q_res[i];
        keep++;
      end
    end
    q_cnt = keep;
  endfunction

  function automatic void predict_dispatch(pjd_req_t rq);
    logic [1:0] st;
    int pos;
    int keep;
    int i;
    st = ST_OK;
    if (rq.load_valid) begin
      base_load = int'(rq.load_sample);
      run_at_sample = run_cnt;
    end
    case (rq.action)
      ACT_ENQ_PRIO, ACT_ENQ_HEAD: begin
        if (q_cnt >= QDEPTH) begin
          st = ST_FULL;
        end else begin
          pos = 0;
          if (rq.action == ACT_ENQ_PRIO)
            while (pos < q_cnt && !(rq.priority_req > q_prio[pos])) pos++;
          for (int j = q_cnt; j > pos; j--) begin
            q_job[j] = q_job[j-1];
            q_prio[j] = q_prio[j-1];
            q_res[j] = q_res[j-1];
          end
          q_job[pos] = rq.job_id;
          q_prio[pos] = rq.priority_req;
          q_res[pos] = rq.resource_mask;
          q_cnt++;
        end
        dispatch_pass();
      end
      ACT_PURGE: begin
        keep = 0;
        for (int j = 0; j < q_cnt; j++) begin
          if (q_job[j] != rq.job_id) begin
            q_job[keep] = q_job[j];
            q_prio[keep] = q_prio[j];
            q_res[keep] = q_res[j];
            keep++;
          end
        end
        if (keep == q_cnt) st = ST_NOT_FOUND;
        q_cnt = keep;
      end
      ACT_FINISH: begin
        i = 0;
        while (i < run_cnt && r_job[i] != rq.job_id) i++;
        if (i >= run_cnt) begin
          st = ST_NOT_FOUND;
        end else begin
          for (int r = 0; r < NRES; r++)
            if (r_res[i][r] && res_run[r] > 0) res_run[r]--;
          for (; i + 1 < run_cnt; i++) begin
            r_job[i] = r_job[i+1];
            r_res[i] = r_res[i+1];
          end
          run_cnt--;
        end
      end
      ACT_PASS: dispatch_pass();
      default: ;
    endcase
    push_result(KIND_STATUS, 8'd0, st, 1'b1);
  endfunction

  task automatic add_req(logic [2:0] act, logic [7:0] id, logic [7:0] prio, logic [3:0] m,
                         logic lv, logic [7:0] ls);
    stim_t s;
    s.is_cfg = 1'b0;
    s.idx = '0;
    s.data = '0;
    s.req.action = act;
    s.req.job_id = id;
    s.req.priority_req = prio;
    s.req.resource_mask = m;
    s.req.load_valid = lv;
    s.req.load_sample = ls;
    stim_q.push_back(s);
    total_reqs++;
  endtask

  task automatic add_cfg(logic [2:0] idx, logic [7:0] v);
    stim_t s;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = v;
    s.req = '0;
    stim_q.push_back(s);
  endtask

  task automatic add_setting(int mn, int mx, int ld, int l0, int l1, int l2, int l3, int pm);
    add_cfg(REG_PROC_MIN, 8'(mn));
    add_cfg(REG_PROC_MAX, 8'(mx));
    add_cfg(REG_LOAD_LIMIT, 8'(ld));
    add_cfg(REG_RES_LIM_0, 8'(l0));
    add_cfg(REG_RES_LIM_1, 8'(l1));
    add_cfg(REG_RES_LIM_2, 8'(l2));
    add_cfg(REG_RES_LIM_3, 8'(l3));
    add_cfg(REG_PAUSED, 8'(pm));
  endtask

  task automatic add_random(int count);
    int p;
    logic [2:0] act;
    logic [7:0] id;
    logic [7:0] prio;
    for (int n = 0; n < count; n++) begin
      p = int'($urandom_range(99));
      if (p < 35) act = ACT_ENQ_PRIO;
      else if (p < 45) act = ACT_ENQ_HEAD;
      else if (p < 55) act = ACT_PURGE;
      else if (p < 85) act = ACT_FINISH;
      else if (p < 95) act = ACT_PASS;
      else act = 3'($urandom_range(7, 5));
      id = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(19));
      case ($urandom_range(3))
        0: prio = 8'd0;
        1: prio = 8'd255;
        2: prio = 8'($urandom_range(3) * 64);
        default: prio = 8'($urandom_range(255));
      endcase
      add_req(act, id, prio, 4'($urandom_range(15)), $urandom_range(9) < 3,
              8'($urandom_range(255)));
    end
  endtask

  initial begin
    proc_min = 0;
    proc_max = 255;
    load_limit = 255;
    for (int r = 0; r < NRES; r++) begin
      res_limit[r] = 255;
      res_run[r] = 0;
    end
    paused = '0;
    q_cnt = 0;
    run_cnt = 0;
    base_load = 0;
    run_at_sample = 0;

    // The queue fills while nothing may launch; then one pass launches sixteen.
    add_cfg(REG_PROC_MAX, 8'd0);
    for (int n = 0; n < 16; n++)
      add_req(ACT_ENQ_PRIO, 8'(n), 8'(n * 16), n[3:0], 1'b0, 8'd0);
    add_req(ACT_ENQ_HEAD, 8'd255, 8'd255, 4'hF, 1'b1, 8'd255);
    add_cfg(REG_PROC_MAX, 8'd255);
    add_req(ACT_PASS, 8'd0, 8'd0, 4'h0, 1'b1, 8'd0);
    add_req(ACT_FINISH, 8'd15, 8'd0, 4'h0, 1'b0, 8'd0);
    add_req(ACT_FINISH, 8'd200, 8'd0, 4'h0, 1'b0, 8'd0);
    add_req(ACT_PURGE, 8'd77, 8'd0, 4'h0, 1'b0, 8'd0);
    add_req(ACT_ENQ_HEAD, 8'd0, 8'd0, 4'h0, 1'b0, 8'd0);
    add_req(3'd5, 8'd1, 8'd1, 4'h1, 1'b0, 8'd0);
    add_req(3'd6, 8'd2, 8'd2, 4'h2, 1'b0, 8'd0);
    add_req(3'd7, 8'd3, 8'd3, 4'h4, 1'b0, 8'd0);

    add_setting(0, 0, 255, 255, 255, 255, 255, 0);
    add_random(35);
    add_req(ACT_PURGE, 8'd0, 8'd0, 4'h0, 1'b0, 8'd0);
    add_setting(255, 4, 0, 255, 255, 255, 255, 0);
    add_random(35);
    add_setting(2, 12, 5, 1, 2, 0, 3, 4'b0100);
    add_random(35);
    add_setting(1, 255, 0, 255, 255, 255, 255, 4'b1111);
    add_random(35);
    add_setting(int'($urandom_range(255)), int'($urandom_range(16)),
                int'($urandom_range(255)), int'($urandom_range(4)),
                int'($urandom_range(4)), int'($urandom_range(4)),
                int'($urandom_range(4)), int'($urandom_range(15)));
    add_random(35);
    add_setting(0, 255, 255, 255, 255, 255, 255, 0);
    add_random(60);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_q.size() == 0 && awaited_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic       nxt_start;
    logic       nxt_cfgv;
    pjd_req_t   nxt_req;
    logic [2:0] nxt_idx;
    logic [7:0] nxt_data;
    int         idle_pct;
    if (!rst_ni) begin
      start <= 1'b0;
      req_d <= '0;
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data <= '0;
      calm = 0;
    end else begin
      nxt_start = start;
      nxt_cfgv = cfg_valid;
      nxt_req = req_d;
      nxt_idx = cfg_index;
      nxt_data = cfg_data;
      if (start && !busy) begin
        predict_dispatch(req_d);
        void'(stim_q.pop_front());
        sent++;
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready_o) begin
        write_reg(cfg_index, cfg_data);
        void'(stim_q.pop_front());
        nxt_cfgv = 1'b0;
      end
      if (awaited_results.size() == 0 && !busy && !start) calm++;
      else calm = 0;
      if (sent < total_reqs / 3) idle_pct = 36;
      else if (sent < 2 * total_reqs / 3) idle_pct = 74;
      else idle_pct = 0;
      if (!nxt_start && !nxt_cfgv && stim_q.size() > 0) begin
        if (stim_q[0].is_cfg) begin
          if (calm >= SETTLE) begin
            nxt_cfgv = 1'b1;
            nxt_idx = stim_q[0].idx;
            nxt_data = stim_q[0].data;
          end
        end else if ($urandom_range(99) >= idle_pct) begin
          nxt_start = 1'b1;
          nxt_req = stim_q[0].req;
        end
      end
      start <= nxt_start;
      req_d <= nxt_req;
      cfg_valid <= nxt_cfgv;
      cfg_index <= nxt_idx;
      cfg_data <= nxt_data;
    end
  end

  always @(posedge clk_i) begin
    pjd_res_t want;
    if (rst_ni && res_valid_o) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res_o);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (res_o.result_kind !== want.result_kind || res_o.launched_id !== want.launched_id ||
            res_o.status !== want.status || res_o.last !== want.last) begin
          $display("%0t: expected %p, got %p", $time, want, res_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || (cfg_valid && cfg_ready_o) || res_valid_o) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
